// File: design/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    // Default geometry of the console.
    localparam int unsigned ROW_CELLS_DEF   = 80;
    localparam int unsigned SCREEN_ROWS_DEF = 25;
    localparam int unsigned TAB_CELLS_DEF   = 8;
    localparam int unsigned MEM_CELLS_DEF   = 16384;

    // Character codes and the attribute that a cleared cell holds.
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // Operation codes of an input request.
    localparam logic [2:0] OP_CHAR        = 3'd0;
    localparam logic [2:0] OP_SCROLL_UP   = 3'd1;
    localparam logic [2:0] OP_SCROLL_DOWN = 3'd2;
    localparam logic [2:0] OP_CLEAR       = 3'd3;
    localparam logic [2:0] OP_READ        = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [13:0] cell_addr;
    } t_in_item;

    typedef struct packed {
        logic [13:0] cursor_pos;
        logic [13:0] view_start;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } t_out_item;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
    } t_cell;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_load;
        logic clr_start;
        logic clr_step;
        logic scroll_up;
        logic scroll_down;
        logic put_char;
        logic bs_prev;
        logic scan_init;
        logic scan_rd;
        logic scan_hit;
        logic scan_dec;
        logic cell_rd;
        logic view_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_char;
        logic op_up;
        logic op_down;
        logic op_clear;
        logic op_read;
        logic ch_print;
        logic ch_bs;
        logic cur_zero;
        logic row_zero;
        logic tab_zero;
        logic scan_match;
        logic scan_low;
        logic view_need;
        logic clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/tccw_modc.sv
`timescale 1ns / 1ps
`default_nettype none

// Remainder of a value by a constant: multiply by the reciprocal, take back
// the quotient estimate, and fix it with one compare and subtract.
// Three register stages.
module tccw_modc #(
    parameter int unsigned DIV = 8,
    parameter int unsigned XW  = 14
) (
    input  wire logic                    i_clk,
    input  wire logic [XW-1:0]           i_x,
    output logic      [$clog2(DIV)-1:0]  o_rem
);

    localparam int unsigned RW    = $clog2(DIV);
    localparam int unsigned RECIP = (2 ** XW) / DIV;

    logic [XW-1:0]   r_x1;
    logic [2*XW-1:0] r_prod;
    logic [RW:0]     r_est;
    logic [RW-1:0]   r_rem;

    logic [XW-1:0] w_q;
    logic [XW-1:0] w_qd;
    logic [XW-1:0] w_diff;

    // The estimate is low by at most one, so the difference stays below 2*DIV.
    assign w_q    = r_prod[2*XW-1:XW];
    assign w_qd   = w_q * XW'(DIV);
    assign w_diff = r_x1 - w_qd;

    always_ff @(posedge i_clk) begin
        r_x1   <= i_x;
        r_prod <= (2 * XW)'(i_x) * (2 * XW)'(RECIP);
        r_est  <= w_diff[RW:0];
        if (r_est >= (RW + 1)'(DIV)) begin
            r_rem <= RW'(r_est - (RW + 1)'(DIV));
        end else begin
            r_rem <= r_est[RW-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

// File: design/tccw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_dp #(
    parameter int unsigned ROW_CELLS   = tccw_pkg::ROW_CELLS_DEF,
    parameter int unsigned SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int unsigned TAB_CELLS   = tccw_pkg::TAB_CELLS_DEF,
    parameter int unsigned MEM_CELLS   = tccw_pkg::MEM_CELLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data,
    input  wire tccw_pkg::t_in_item  i_in_data,
    input  wire tccw_pkg::t_dp_cmd   i_cmd,
    output tccw_pkg::t_dp_sts        o_sts,
    output tccw_pkg::t_out_item      o_out_data
);

    localparam int unsigned AW           = $clog2(MEM_CELLS);
    localparam int unsigned SCREEN_CELLS = ROW_CELLS * SCREEN_ROWS;
    localparam int unsigned SCW          = $clog2(SCREEN_CELLS + 1);
    localparam int unsigned SW           = ((AW > SCW) ? AW : SCW) + 1;
    localparam int unsigned RRW          = $clog2(ROW_CELLS);
    localparam int unsigned TRW          = $clog2(TAB_CELLS);

    tccw_pkg::t_cell     r_mem [MEM_CELLS];
    tccw_pkg::t_cell     r_q;
    tccw_pkg::t_in_item  r_item;
    tccw_pkg::t_out_item r_out;

    logic [7:0]    r_attr;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [AW-1:0] r_start, n_start;
    logic [AW-1:0] r_clr_cnt;
    logic [AW-1:0] r_scan_i;
    logic [AW-1:0] r_scan_low;
    logic          r_scan_nl;

    logic [RRW-1:0] w_row_rem;
    logic [TRW-1:0] w_tab_rem;

    logic            w_is_tab, w_is_nl, w_is_bs;
    logic [AW:0]     w_step;
    logic [AW-1:0]   w_put;
    logic [SW-1:0]   w_end;
    logic            w_room;
    logic            w_rd_ok;

    logic            w_we;
    logic [AW-1:0]   w_wa;
    tccw_pkg::t_cell w_wd;
    logic            w_re;
    logic [AW-1:0]   w_ra;

    tccw_modc #(.DIV(ROW_CELLS), .XW(AW)) u_row_mod (
        .i_clk (i_clk),
        .i_x   (r_cursor),
        .o_rem (w_row_rem)
    );

    tccw_modc #(.DIV(TAB_CELLS), .XW(AW)) u_tab_mod (
        .i_clk (i_clk),
        .i_x   (r_cursor),
        .o_rem (w_tab_rem)
    );

    assign w_is_tab = (r_item.ch == tccw_pkg::CH_TAB);
    assign w_is_nl  = (r_item.ch == tccw_pkg::CH_NL);
    assign w_is_bs  = (r_item.ch == tccw_pkg::CH_BS);

    // Next cursor of a character: the next tab stop, the next row or the next cell,
    // held at the last cell of the memory.
    always_comb begin
        if (w_is_tab) begin
            w_step = (AW + 1)'(r_cursor) - (AW + 1)'(w_tab_rem) + (AW + 1)'(TAB_CELLS);
        end else if (w_is_nl) begin
            w_step = (AW + 1)'(r_cursor) - (AW + 1)'(w_row_rem) + (AW + 1)'(ROW_CELLS);
        end else begin
            w_step = (AW + 1)'(r_cursor) + (AW + 1)'(1);
        end
        if (w_step >= (AW + 1)'(MEM_CELLS)) begin
            w_put = AW'(MEM_CELLS - 1);
        end else begin
            w_put = w_step[AW-1:0];
        end
    end

    assign w_end  = SW'(r_start) + SW'(SCREEN_CELLS);
    assign w_room = (w_end < SW'(MEM_CELLS));
    assign w_rd_ok = (r_item.op == tccw_pkg::OP_READ) &&
                     ({18'd0, r_item.cell_addr} < 32'(MEM_CELLS));

    // Cell memory ports.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_cursor;
        w_wd = '{ch: tccw_pkg::CH_SPACE, attr: r_attr};
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
            w_wa = r_clr_cnt;
            w_wd = '{ch: tccw_pkg::CH_SPACE, attr: tccw_pkg::RESET_ATTR};
        end else if (i_cmd.put_char) begin
            w_we = 1'b1;
            w_wa = r_cursor;
            if (w_is_tab || w_is_nl) begin
                w_wd = '{ch: r_item.ch, attr: 8'h00};
            end else begin
                w_wd = '{ch: r_item.ch, attr: r_attr};
            end
        end else if (i_cmd.bs_prev) begin
            w_we = 1'b1;
            w_wa = r_cursor - AW'(1);
        end else if (i_cmd.scan_hit) begin
            w_we = 1'b1;
            w_wa = r_scan_i;
        end
        w_re = i_cmd.scan_rd || i_cmd.cell_rd;
        w_ra = i_cmd.scan_rd ? r_scan_i : AW'(r_item.cell_addr);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_q <= r_mem[w_ra];
        end
    end

    always_comb begin
        n_cursor = r_cursor;
        if (i_cmd.clr_start) begin
            n_cursor = '0;
        end else if (i_cmd.put_char) begin
            n_cursor = w_put;
        end else if (i_cmd.bs_prev) begin
            n_cursor = r_cursor - AW'(1);
        end else if (i_cmd.scan_hit) begin
            n_cursor = r_scan_i;
        end

        n_start = r_start;
        if (i_cmd.scroll_up) begin
            if (r_start >= AW'(ROW_CELLS)) begin
                n_start = r_start - AW'(ROW_CELLS);
            end else begin
                n_start = '0;
            end
        end else if ((i_cmd.scroll_down && w_room) || i_cmd.view_step) begin
            n_start = r_start + AW'(ROW_CELLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= tccw_pkg::RESET_ATTR;
            r_cursor  <= '0;
            r_start   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            r_cursor <= n_cursor;
            r_start  <= n_start;
            if (i_cmd.clr_start) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_init) begin
            r_scan_i <= r_cursor;
            r_scan_nl <= (w_row_rem == '0);
            if (w_row_rem == '0) begin
                r_scan_low <= r_cursor - AW'(ROW_CELLS);
            end else begin
                r_scan_low <= r_cursor - AW'(TAB_CELLS);
            end
        end else if (i_cmd.scan_dec) begin
            r_scan_i <= r_scan_i - AW'(1);
        end
        if (i_cmd.out_load) begin
            r_out.cursor_pos <= 14'(r_cursor);
            r_out.view_start <= 14'(r_start);
            r_out.read_char  <= w_rd_ok ? r_q.ch : 8'h00;
            r_out.read_attr  <= w_rd_ok ? r_q.attr : 8'h00;
        end
    end

    always_comb begin
        o_sts.op_char    = (r_item.op == tccw_pkg::OP_CHAR);
        o_sts.op_up      = (r_item.op == tccw_pkg::OP_SCROLL_UP);
        o_sts.op_down    = (r_item.op == tccw_pkg::OP_SCROLL_DOWN);
        o_sts.op_clear   = (r_item.op == tccw_pkg::OP_CLEAR);
        o_sts.op_read    = (r_item.op == tccw_pkg::OP_READ);
        o_sts.ch_print   = !(w_is_tab || w_is_nl || w_is_bs);
        o_sts.ch_bs      = w_is_bs;
        o_sts.cur_zero   = (r_cursor == '0);
        o_sts.row_zero   = (w_row_rem == '0);
        o_sts.tab_zero   = (w_tab_rem == '0);
        o_sts.scan_match = (r_q.ch == tccw_pkg::CH_TAB) ||
                           (r_scan_nl && (r_q.ch == tccw_pkg::CH_NL));
        o_sts.scan_low   = (r_scan_i == r_scan_low);
        o_sts.view_need  = (SW'(r_cursor) >= w_end) && w_room;
        o_sts.clr_last   = (r_clr_cnt == AW'(MEM_CELLS - 1));
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// File: design/tccw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    input  wire tccw_pkg::t_dp_sts  i_sts,
    output tccw_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_DEC     = 10'b00_0000_0100,
        S_MOD1    = 10'b00_0000_1000,
        S_MOD2    = 10'b00_0001_0000,
        S_MOD3    = 10'b00_0010_0000,
        S_SCAN_RD = 10'b00_0100_0000,
        S_SCAN_CK = 10'b00_1000_0000,
        S_VIEW    = 10'b01_0000_0000,
        S_FIN     = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_op, n_clr_op;
    logic   r_out_valid;
    logic   w_slot;

    // The output register is free, or its request leaves at this edge.
    assign w_slot = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_clr_op = r_clr_op;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state  = r_clr_op ? S_FIN : S_IDLE;
                    n_clr_op = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.op_char) begin
                    if (i_sts.ch_print) begin
                        o_cmd.put_char = 1'b1;
                        n_state = S_VIEW;
                    end else if (i_sts.ch_bs && i_sts.cur_zero) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MOD1;
                    end
                end else if (i_sts.op_up) begin
                    o_cmd.scroll_up = 1'b1;
                    n_state = S_FIN;
                end else if (i_sts.op_down) begin
                    o_cmd.scroll_down = 1'b1;
                    n_state = S_FIN;
                end else if (i_sts.op_clear) begin
                    o_cmd.clr_start = 1'b1;
                    n_clr_op = 1'b1;
                    n_state = S_CLEAR;
                end else if (i_sts.op_read) begin
                    o_cmd.cell_rd = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MOD1: begin
                n_state = S_MOD2;
            end
            S_MOD2: begin
                n_state = S_MOD3;
            end
            S_MOD3: begin
                if (i_sts.ch_bs) begin
                    if (i_sts.row_zero || i_sts.tab_zero) begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN_RD;
                    end else begin
                        o_cmd.bs_prev = 1'b1;
                        n_state = S_VIEW;
                    end
                end else begin
                    o_cmd.put_char = 1'b1;
                    n_state = S_VIEW;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (i_sts.scan_match) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state = S_VIEW;
                end else if (i_sts.scan_low) begin
                    o_cmd.bs_prev = 1'b1;
                    n_state = S_VIEW;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_VIEW: begin
                if (i_sts.view_need) begin
                    o_cmd.view_step = 1'b1;
                end else if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (w_slot) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr_op <= n_clr_op;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_in_valid/o_in_ready   i_in_data   (op, ch, cell_addr)
// output    out        o_out_valid/i_out_ready o_out_data  (cursor, view, char, attr)
// config    in         i_cfg_valid/o_cfg_ready i_cfg_data  (text attribute)
//
// Tab, newline and other backspaces wait on the cursor remainder pipelines, which a printable
// character, a scroll, a read, an unused op or a backspace at cell zero skip; a backspace at a tab
// stop or row start then scans back cell by cell. A character moves the view down one row at a
// time while the cursor is past it, and a clear writes every cell. Reset starts a clearing pass
// over all MEM_CELLS cells; configuration writes are taken at any time.
// A stalled output holds its result while the next request is already at work.
module text_console_char_writer_core #(
    parameter int unsigned ROW_CELLS   = tccw_pkg::ROW_CELLS_DEF,
    parameter int unsigned SCREEN_ROWS = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int unsigned TAB_CELLS   = tccw_pkg::TAB_CELLS_DEF,
    parameter int unsigned MEM_CELLS   = tccw_pkg::MEM_CELLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tccw_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tccw_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);

    tccw_pkg::t_dp_cmd w_cmd;
    tccw_pkg::t_dp_sts w_sts;

    // The attribute register is a plain register and can take a write every cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each request; it sees the datapath only
    // through the command and status structs.
    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the cell memory, the cursor, the view start, the
    // remainder pipelines and the result register.
    tccw_dp #(
        .ROW_CELLS   (ROW_CELLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .TAB_CELLS   (TAB_CELLS),
        .MEM_CELLS   (MEM_CELLS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
